/* hw/rtl/pal_pkg.sv */
// Shared types and constants of the positional array list.
package pal_pkg;

	// Fixed field widths of the request and response beats
	localparam int CMD_W    = 2;
	localparam int POS_W    = 5;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Default sizing of the list
	localparam int CAPACITY_DEF   = 16;
	localparam int VALUE_BITS_DEF = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_SET    = 2'd2,
		CMD_GET    = 2'd3
	} pal_cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} pal_status_t;

	// Operation broadcast to every cell; at most one bit is set
	typedef struct packed {
		logic ins;
		logic rem;
		logic wr;
	} pal_op_t;

endpackage

/* hw/rtl/pal_in_if.sv */
// Request channel: command, position and value with valid/ready.
interface pal_in_if import pal_pkg::*; ();
	logic                valid;
	logic                ready;
	pal_cmd_t            command;
	logic [POS_W-1:0]    position;
	logic [DATA_W-1:0]   value;

	modport source (output valid, command, position, value, input ready);
	modport sink   (input valid, command, position, value, output ready);
endinterface

/* hw/rtl/pal_out_if.sv */
// Response channel: read value, status and entry count with valid/ready.
interface pal_out_if import pal_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [DATA_W-1:0]   read_value;
	pal_status_t         status;
	logic [COUNT_W-1:0]  item_count;

	modport source (output valid, read_value, status, item_count, input ready);
	modport sink   (input valid, read_value, status, item_count, output ready);
endinterface

/* hw/rtl/pal_cell.sv */
// One list slot: holds an entry and moves it up, down or loads a new value.
module pal_cell import pal_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int POSW       = 5,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  pal_op_t               op,
	input  logic [POSW-1:0]       pos,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [VALUE_BITS-1:0] prev,
	input  logic [VALUE_BITS-1:0] next,
	output logic [VALUE_BITS-1:0] entry,
	output logic [VALUE_BITS-1:0] rd_part
);

	localparam logic [POSW-1:0] IDX = POSW'(INDEX);

	logic                  hit;
	logic                  above;
	logic [VALUE_BITS-1:0] entry_q;

	assign hit   = (IDX == pos);
	assign above = (IDX > pos);

	always_ff @(posedge clk) begin
		if ((op.ins || op.wr) && hit) begin
			entry_q <= value;
		end else if (op.ins && above) begin
			entry_q <= prev;
		end else if (op.rem && (above || hit)) begin
			entry_q <= next;
		end
	end

	assign entry   = entry_q;
	assign rd_part = hit ? entry_q : '0;

endmodule

/* hw/rtl/positional_array_list_top.sv */
// Positional array list top level: row of entry cells, count and response register.
//
// Ordered list of up to CAPACITY values of VALUE_BITS each. Every entry sits in
// its own cell; for insert, remove, set and get all cells shift or load together,
// so one request beat is taken every cycle unless a response waits untaken. The
// response (read value, status, count after the operation) is registered and
// shows on rsp in the cycle after the request beat; req.ready drops only while a
// response waits untaken. Status is done, full (insert into a full list, checked
// first) or out of range (insert past the end, or remove/set/get at or beyond the
// count). read_value is zero except for a successful get. Entry storage has no
// reset; only entries below the count are ever read, and those were written.
// Values wider than VALUE_BITS are cut to VALUE_BITS on entry; the count is
// reported in its low five bits.
module positional_array_list_top import pal_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pal_in_if.sink     req,
	pal_out_if.source  rsp
);

	// count spans 0..CAPACITY; comparisons run at the wider of it and position
	localparam int CNTW = $clog2(CAPACITY + 1);
	localparam int CMPW = (CNTW > POS_W) ? CNTW : POS_W;

	logic [CNTW-1:0]       count_q;
	logic [CNTW-1:0]       count_nxt;
	logic [CMPW-1:0]       pos_w;
	logic [CMPW-1:0]       count_w;
	logic [CNTW-1:0]       pos_c;
	logic                  accept;
	logic                  full;
	pal_status_t           status;
	pal_op_t               op;
	logic [VALUE_BITS-1:0] value_c;
	logic [VALUE_BITS-1:0] rd_or;
	logic [DATA_W-1:0]     read_value;

	logic [VALUE_BITS-1:0] entry   [CAPACITY];
	logic [VALUE_BITS-1:0] rd_part [CAPACITY];

	// response register
	logic                  rsp_valid_q;
	logic [DATA_W-1:0]     read_value_q;
	pal_status_t           status_q;
	logic [COUNT_W-1:0]    item_count_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign pos_w   = CMPW'(req.position);
	assign count_w = CMPW'(count_q);
	// only used by the cells once the range check passed, so it fits in CNTW
	assign pos_c   = pos_w[CNTW-1:0];
	assign full    = (count_q == CNTW'(CAPACITY));
	assign value_c = VALUE_BITS'(req.value);

	always_comb begin
		status = ST_DONE;
		case (req.command)
			CMD_INSERT: begin
				if (full) begin
					status = ST_FULL;
				end else if (pos_w > count_w) begin
					status = ST_RANGE;
				end
			end
			default: begin
				if (pos_w >= count_w) begin
					status = ST_RANGE;
				end
			end
		endcase
	end

	always_comb begin
		op.ins = accept && (status == ST_DONE) && (req.command == CMD_INSERT);
		op.rem = accept && (status == ST_DONE) && (req.command == CMD_REMOVE);
		op.wr  = accept && (status == ST_DONE) && (req.command == CMD_SET);
	end

	always_comb begin
		count_nxt = count_q;
		if (op.ins) begin
			count_nxt = count_q + CNTW'(1);
		end else if (op.rem) begin
			count_nxt = count_q - CNTW'(1);
		end
	end

	// row of cells; insert takes from the lower neighbor, remove from the upper
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_BITS-1:0] prev_d;
		logic [VALUE_BITS-1:0] next_d;

		if (i == 0) begin : g_first
			assign prev_d = '0;
		end else begin : g_mid_lo
			assign prev_d = entry[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_d = '0;
		end else begin : g_mid_hi
			assign next_d = entry[i+1];
		end

		pal_cell #(
			.VALUE_BITS (VALUE_BITS),
			.POSW       (CNTW),
			.INDEX      (i)
		) u_cell (
			.clk     (clk),
			.op      (op),
			.pos     (pos_c),
			.value   (value_c),
			.prev    (prev_d),
			.next    (next_d),
			.entry   (entry[i]),
			.rd_part (rd_part[i])
		);
	end

	// only the addressed cell drives a nonzero read part
	always_comb begin
		rd_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_or = rd_or | rd_part[i];
		end
	end

	assign read_value = ((req.command == CMD_GET) && (status == ST_DONE)) ?
		DATA_W'(rd_or) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= read_value;
			status_q     <= status;
			item_count_q <= COUNT_W'(count_nxt);
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = read_value_q;
	assign rsp.status     = status_q;
	assign rsp.item_count = item_count_q;

	// count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(CAPACITY))
		else $error("entry count above capacity");

	// count moves only on an accepted beat
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("entry count changed without a request beat");

	// insert into a full list reports full and leaves the count alone
	a_full_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.command == CMD_INSERT) && full) |=>
		(status_q == ST_FULL) && $stable(count_q))
		else $error("insert into full list not flagged");

	// failed operations never return data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (status_q != ST_DONE)) |-> (read_value_q == '0))
		else $error("nonzero read value on failed operation");

endmodule

/* test/tb_positional_array_list_top.sv */
// Testbench for positional_array_list_top: random list traffic checked against a shadow list.
`timescale 1ns / 100ps

module tb_positional_array_list_top import pal_pkg::*; ();

	localparam int               RANDOM_BEATS = 1300;
	localparam int               MAX_IDLE     = 17;
	localparam logic [POS_W-1:0] POS_MAX      = '1;

	// One response beat as the list should produce it
	typedef struct {
		logic [DATA_W-1:0]  read_value;
		pal_status_t        status;
		logic [COUNT_W-1:0] item_count;
	} list_rsp_t;

	// Shadow copy of the list. Every accepted request beat updates it and queues
	// the response it must cause; response beats are matched in order.
	class list_tracker;
		logic [DATA_W-1:0] shadow [CAPACITY_DEF];
		int                held;
		list_rsp_t         expected_rsp [$];
		int                mismatches;

		function void take_request(pal_cmd_t cmd, logic [POS_W-1:0] pos,
				logic [DATA_W-1:0] val);
			list_rsp_t e;
			int        p;
			int        i;
			p            = int'(pos);
			e.read_value = '0;
			e.status     = ST_DONE;
			case (cmd)
				CMD_INSERT: begin
					// full is checked ahead of the position
					if (held >= CAPACITY_DEF) begin
						e.status = ST_FULL;
					end else if (p > held) begin
						e.status = ST_RANGE;
					end else begin
						for (i = held; i > p; i--)
							shadow[i] = shadow[i-1];
						shadow[p] = val;
						held++;
					end
				end
				CMD_REMOVE: begin
					if (p >= held) begin
						e.status = ST_RANGE;
					end else begin
						for (i = p; i + 1 < held; i++)
							shadow[i] = shadow[i+1];
						held--;
					end
				end
				CMD_SET: begin
					if (p >= held)
						e.status = ST_RANGE;
					else
						shadow[p] = val;
				end
				default: begin
					if (p >= held)
						e.status = ST_RANGE;
					else
						e.read_value = shadow[p];
				end
			endcase
			e.item_count = held[COUNT_W-1:0];
			expected_rsp.push_back(e);
		endfunction

		function void check_response(logic [DATA_W-1:0] rv, pal_status_t st,
				logic [COUNT_W-1:0] cnt);
			list_rsp_t e;
			if (expected_rsp.size() == 0) begin
				$error("response beat with nothing pending: read_value %h status %0d count %0d",
					rv, st, cnt);
				mismatches++;
				return;
			end
			e = expected_rsp.pop_front();
			if (rv !== e.read_value) begin
				$error("read_value: expected %h, got %h", e.read_value, rv);
				mismatches++;
			end
			if (st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st);
				mismatches++;
			end
			if (cnt !== e.item_count) begin
				$error("item_count: expected %0d, got %0d", e.item_count, cnt);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	pal_in_if  req ();
	pal_out_if rsp ();

	list_tracker tracker = new;

	// When set, the matching side runs back to back with no idle cycles
	bit req_steady;
	bit rsp_steady;

	positional_array_list_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// 4 ns clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int idle_cycles(bit steady);
		return steady ? 0 : $urandom_range(0, MAX_IDLE);
	endfunction

	// Present one request beat and hold it until the block takes it.
	// Called at a rising edge; valid is only touched once per time step, so a
	// back-to-back beat just replaces the payload with valid left high.
	task automatic send_beat(pal_cmd_t cmd, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
		int gap;
		gap = idle_cycles(req_steady);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid    <= 1'b1;
		req.command  <= cmd;
		req.position <= pos;
		req.value    <= val;
		do @(posedge clk); while (!req.ready);
		tracker.take_request(cmd, pos, val);
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// One random beat; weights are percentages for insert, remove and set,
	// get takes the rest. Most positions land inside the list so that the
	// shifts really move data; a tenth go anywhere in the field's range.
	task automatic random_beat(int w_ins, int w_rem, int w_set);
		pal_cmd_t         cmd;
		logic [POS_W-1:0] pos;
		int               r;
		r = $urandom_range(0, 99);
		if (r < w_ins)
			cmd = CMD_INSERT;
		else if (r < w_ins + w_rem)
			cmd = CMD_REMOVE;
		else if (r < w_ins + w_rem + w_set)
			cmd = CMD_SET;
		else
			cmd = CMD_GET;
		if ($urandom_range(0, 9) == 0)
			pos = POS_W'($urandom_range(0, int'(POS_MAX)));
		else if (cmd == CMD_INSERT)
			pos = POS_W'($urandom_range(0, tracker.held));
		else
			pos = (tracker.held == 0) ? '0 :
				POS_W'($urandom_range(0, tracker.held - 1));
		send_beat(cmd, pos, pick_value());
	endtask

	// Response side: stall a random number of cycles before each beat, with
	// stretches of constant ready mixed in; every taken beat is checked.
	initial begin
		int taken;
		taken      = 0;
		rsp_steady = 1'b0;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			int gap;
			if (taken % 40 == 0)
				rsp_steady = ($urandom_range(0, 3) == 0);
			gap = idle_cycles(rsp_steady);
			if (gap > 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
			tracker.check_response(rsp.read_value, rsp.status, rsp.item_count);
			taken++;
		end
	end

	// Main sequence
	initial begin
		int sent;
		int phase_len;
		int kind;
		arst_n       <= 1'b0;
		req.valid    <= 1'b0;
		req.command  <= CMD_INSERT;
		req.position <= '0;
		req.value    <= '0;
		req_steady    = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty list errors, insert at front/middle/end, reads of
		// every entry, out-of-range accesses, then remove down to empty.
		send_beat(CMD_GET,    0, 32'h0);
		send_beat(CMD_REMOVE, 0, 32'h0);
		send_beat(CMD_SET,    0, 32'hDEAD_BEEF);
		send_beat(CMD_INSERT, 1, 32'h1111_1111);   // past the end of an empty list
		send_beat(CMD_INSERT, 0, 32'hFFFF_FFFF);
		send_beat(CMD_INSERT, 0, 32'h0000_0000);   // front
		send_beat(CMD_INSERT, 2, 32'hA5A5_A5A5);   // append at position == count
		send_beat(CMD_INSERT, 1, 32'h5A5A_5A5A);   // middle
		send_beat(CMD_GET,    0, 32'h0);
		send_beat(CMD_GET,    1, 32'h0);
		send_beat(CMD_GET,    2, 32'h0);
		send_beat(CMD_GET,    3, 32'h0);
		send_beat(CMD_GET,    4, 32'h0);           // == count
		send_beat(CMD_GET,    POS_MAX, 32'h0);
		send_beat(CMD_SET,    3, 32'h1234_5678);   // last entry
		send_beat(CMD_SET,    4, 32'hFFFF_FFFF);
		send_beat(CMD_REMOVE, POS_MAX, 32'h0);
		send_beat(CMD_REMOVE, 1, 32'h0);           // middle
		send_beat(CMD_REMOVE, 2, 32'h0);           // last
		send_beat(CMD_GET,    1, 32'h0);
		send_beat(CMD_REMOVE, 0, 32'h0);
		send_beat(CMD_REMOVE, 0, 32'h0);           // list empty again
		send_beat(CMD_GET,    0, 32'h0);

		// Random phases: fill (drives the list into full), drain and mixed.
		// The first phase always fills.
		sent = 0;
		kind = 0;
		while (sent < RANDOM_BEATS) begin
			phase_len  = $urandom_range(30, 80);
			req_steady = ($urandom_range(0, 3) == 0);
			repeat (phase_len) begin
				case (kind)
					0:       random_beat(80,  5,  5);
					1:       random_beat( 5, 75, 10);
					default: random_beat(30, 25, 20);
				endcase
				sent++;
			end
			kind = $urandom_range(0, 2);
		end
		req.valid <= 1'b0;

		// drain outstanding responses, then allow for the register stage
		while (tracker.expected_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("positional_array_list_top test passed");
		else
			$display("positional_array_list_top test failed");
		$finish;
	end

	// Hang guard, far beyond the slowest legal run (~200 us)
	initial begin
		#2_000_000;
		$display("positional_array_list_top test failed");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/pal_pkg.sv
hw/rtl/pal_in_if.sv
hw/rtl/pal_out_if.sv
hw/rtl/pal_cell.sv
hw/rtl/positional_array_list_top.sv
test/tb_positional_array_list_top.sv
